// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// ante at an edge implies cons at the same edge
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/swmm_pkg.sv =====
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared constants and types of the sliding window statistics block.
// ----------------------------------------------------------------------------
package swmm_pkg;

   localparam int WINDOW   = 20;
   localparam int SAMPLE_W = 7;
   localparam int FILL_W   = 5;
   localparam int MEAN_W   = 15;
   localparam int FRAC_W   = 8;

   // count runs 0..WINDOW, ring index 0..WINDOW-1
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W = $clog2(((1 << SAMPLE_W) - 1) * WINDOW + 1);
   localparam int DVD_W = SUM_W + FRAC_W;
   localparam int STEP_W = $clog2(DVD_W + 1);

   localparam logic [FILL_W-1:0]   FILL_SAT   = '1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== src/swmm_if.sv =====
// ----------------------------------------------------------------------------
// swmm channels
// Valid/ready channels for sample items and statistics items.
// ----------------------------------------------------------------------------
interface swmm_req_if;
   import swmm_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swmm_rsp_if;
   import swmm_pkg::*;

   logic                valid;
   logic                ready;
   logic [FILL_W-1:0]   fill_count;
   logic [MEAN_W-1:0]   mean_q8;
   logic [SAMPLE_W-1:0] max_value;
   logic [SAMPLE_W-1:0] min_value;

   modport source (output valid, output fill_count, output mean_q8,
                   output max_value, output min_value, input ready);
   modport sink   (input valid, input fill_count, input mean_q8,
                   input max_value, input min_value, output ready);
endinterface

// ===== src/sliding_window_mean_max_min.sv =====
// Items are handled one at a time; the scan reads one memory entry per cycle over the N
// samples held (1..WINDOW). The next item is accepted once the result sits in the output
// register, which is loaded only when empty or when its result is being taken. Synchronous
// active-high reset clears count, write pointer and handshakes; ring contents stay
// undefined until written.
// ----------------------------------------------------------------------------
// sliding_window_mean_max_min
// Ring of recent samples in a one-port-write, one-port-read memory; each item
// is written, then the held entries are scanned for sum, max and min, and the
// mean is formed by a serial divide.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_mean_max_min (
   input  logic       clock,
   input  logic       reset,
   swmm_req_if.sink   req_ch,
   swmm_rsp_if.source rsp_ch
);
   import swmm_pkg::*;

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;

   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [IDX_W-1:0]    wpos_ff, wpos_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] hi_ff, hi_in;
   logic [SAMPLE_W-1:0] lo_ff, lo_in;

   logic                out_vld_ff, out_vld_in;
   logic [FILL_W-1:0]   out_fill_ff, out_fill_in;
   logic [MEAN_W-1:0]   out_mean_ff, out_mean_in;
   logic [SAMPLE_W-1:0] out_hi_ff, out_hi_in;
   logic [SAMPLE_W-1:0] out_lo_ff, out_lo_in;

   logic                accept, wr_en, rd_issue, scan_end, div_start, load_out;
   logic                div_done;
   logic [DVD_W-1:0]    quotient;
   logic [7:0]          cnt_wide;

   assign accept   = req_ch.valid && req_ch.ready;
   assign scan_end = (rd_idx_ff == cnt_ff) && !rd_vld_ff;
   assign cnt_wide = 8'(cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_ch.valid) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_SCAN;
         ST_SCAN:  if (scan_end) state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_DONE;
         ST_DONE:  if (!out_vld_ff || rsp_ch.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ch.ready = 1'b0;
      wr_en        = 1'b0;
      rd_issue     = 1'b0;
      div_start    = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ch.ready = 1'b1;
         ST_WRITE: wr_en = 1'b1;
         ST_SCAN: begin
            rd_issue  = rd_idx_ff != cnt_ff;
            div_start = scan_end;
         end
         ST_DIV:   ;
         ST_DONE:  load_out = !out_vld_ff || rsp_ch.ready;
         default:  ;
      endcase
   end

   // datapath next values
   always_comb begin
      sample_in = accept ? req_ch.sample : sample_ff;
      wpos_in   = wpos_ff;
      cnt_in    = cnt_ff;
      rd_idx_in = rd_idx_ff;
      rd_vld_in = rd_issue;
      sum_in    = sum_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      if (wr_en) begin
         wpos_in   = (wpos_ff == IDX_W'(WINDOW - 1)) ? '0 : wpos_ff + 1'b1;
         cnt_in    = (cnt_ff == CNT_W'(WINDOW)) ? cnt_ff : cnt_ff + 1'b1;
         rd_idx_in = '0;
         sum_in    = '0;
         hi_in     = '0;
         lo_in     = SAMPLE_TOP;
      end
      if (rd_issue) rd_idx_in = rd_idx_ff + 1'b1;
      // read data is registered and lands in the cycle after its address
      if (rd_vld_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data_ff);
         if (rd_data_ff > hi_ff) hi_in = rd_data_ff;
         if (rd_data_ff < lo_ff) lo_in = rd_data_ff;
      end
   end

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_fill_in = out_fill_ff;
      out_mean_in = out_mean_ff;
      out_hi_in   = out_hi_ff;
      out_lo_in   = out_lo_ff;
      if (rsp_ch.valid && rsp_ch.ready) out_vld_in = 1'b0;
      if (load_out) begin
         out_vld_in  = 1'b1;
         out_fill_in = (cnt_wide > 8'(FILL_SAT)) ? FILL_SAT : cnt_wide[FILL_W-1:0];
         out_mean_in = quotient[MEAN_W-1:0];
         out_hi_in   = hi_ff;
         out_lo_in   = lo_ff;
      end
   end

   // ring memory: write in WRITE, scan reads start the cycle after
   always_ff @(posedge clock) begin
      if (wr_en) ring_mem[wpos_ff] <= sample_ff;
      rd_data_ff <= ring_mem[rd_idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wpos_ff    <= '0;
         cnt_ff     <= '0;
         rd_idx_ff  <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wpos_ff    <= wpos_in;
         cnt_ff     <= cnt_in;
         rd_idx_ff  <= rd_idx_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      sum_ff      <= sum_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      out_fill_ff <= out_fill_in;
      out_mean_ff <= out_mean_in;
      out_hi_ff   <= out_hi_in;
      out_lo_ff   <= out_lo_in;
   end

   swmm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, FRAC_W'(0)}),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_ch.valid      = out_vld_ff;
   assign rsp_ch.fill_count = out_fill_ff;
   assign rsp_ch.mean_q8    = out_mean_ff;
   assign rsp_ch.max_value  = out_hi_ff;
   assign rsp_ch.min_value  = out_lo_ff;

   `ASSERT_ALWAYS(a_cnt_range, clock, reset, cnt_ff <= CNT_W'(WINDOW) && wpos_ff <= IDX_W'(WINDOW - 1), "ring count or pointer out of range")
   `ASSERT_ALWAYS(a_scan_bound, clock, reset, rd_idx_ff <= cnt_ff, "scan index passed fill count")
   `ASSERT_IMPLIES(a_div_done_state, clock, reset, div_done, state_ff == ST_DIV, "divide finished outside divide state")
   `ASSERT_IMPLIES(a_rsp_from_done, clock, reset, $rose(out_vld_ff), $past(state_ff) == ST_DONE, "result appeared without finishing an item")
   `ASSERT_IMPLIES(a_scan_nonempty, clock, reset, state_ff == ST_SCAN, cnt_ff != '0, "scan over an empty window")

endmodule

// ===== src/swmm_div.sv =====
// ----------------------------------------------------------------------------
// swmm_div
// Restoring divider, one quotient bit per cycle, DVD_W quotient bits per divide.
// ----------------------------------------------------------------------------
module swmm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [swmm_pkg::DVD_W-1:0] dividend,
   input  logic [swmm_pkg::CNT_W-1:0] divisor,
   output logic                       done,
   output logic [swmm_pkg::DVD_W-1:0] quotient
);
   import swmm_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;

   logic [CNT_W:0]    trial;
   logic              fits;

   // dividend bits shift out the top while quotient bits shift in below
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         rem_in  = fits ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== bench/sliding_window_mean_max_min_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_mean_max_min_tb
// Sends brightness samples through the sample channel and checks every
// statistics item (fill count, q8 mean, max, min) against a predictor that
// keeps its own ring of recent samples. Both channels idle at random.
// ----------------------------------------------------------------------------
module sliding_window_mean_max_min_tb;
   import swmm_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 60;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct packed {
      logic [FILL_W-1:0]   fill_count;
      logic [MEAN_W-1:0]   mean_q8;
      logic [SAMPLE_W-1:0] max_value;
      logic [SAMPLE_W-1:0] min_value;
   } window_stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   swmm_req_if req_ch ();
   swmm_rsp_if rsp_ch ();

   sliding_window_mean_max_min dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state: ring of held samples
   logic [SAMPLE_W-1:0] ring_samples [WINDOW];
   int unsigned         ring_wr_idx = 0;
   int unsigned         ring_count = 0;

   window_stats_type expected_stats [$];
   int unsigned      error_count = 0;
   int unsigned      idle_cycles = 0;
   bit               req_idle_on = 1'b1;
   bit               rsp_idle_on = 1'b1;

   function automatic window_stats_type predict_window_stats(input logic [SAMPLE_W-1:0] s);
      int unsigned         total;
      logic [SAMPLE_W-1:0] hi;
      logic [SAMPLE_W-1:0] lo;
      window_stats_type    r;
      ring_samples[ring_wr_idx] = s;
      ring_wr_idx = (ring_wr_idx == WINDOW - 1) ? 0 : ring_wr_idx + 1;
      if (ring_count < WINDOW) ring_count++;
      total = 0;
      hi = '0;
      lo = SAMPLE_TOP;
      for (int i = 0; i < ring_count; i++) begin
         total += ring_samples[i];
         if (ring_samples[i] > hi) hi = ring_samples[i];
         if (ring_samples[i] < lo) lo = ring_samples[i];
      end
      r.fill_count = (ring_count > FILL_SAT) ? FILL_SAT : FILL_W'(ring_count);
      r.mean_q8    = MEAN_W'((total << FRAC_W) / ring_count);
      r.max_value  = hi;
      r.min_value  = lo;
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      gap = pick_gap(req_idle_on);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_stats.push_back(predict_window_stats(s));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_stats.size() != 0) @(posedge clock);
   endtask

   // fills the window from empty with extremes and single-bit patterns
   task automatic test_ring_fill();
      logic [SAMPLE_W-1:0] fill_seq [20] = '{
         7'd0, 7'd127, 7'd100, 7'd1, 7'd64, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32,
         7'd101, 7'd0, 7'd99, 7'd63, 7'd50, 7'd126, 7'd85, 7'd42, 7'd3, 7'd100
      };
      foreach (fill_seq[i]) send_sample(fill_seq[i]);
   endtask

   // first items after the ring is full overwrite the oldest entries
   task automatic test_ring_wrap();
      send_sample(7'd127);
      send_sample(7'd127);
      send_sample(7'd0);
      send_sample(7'd100);
      send_sample(7'd55);
   endtask

   // sender holds off until every result is back, then resumes
   task automatic test_drain_pause();
      wait_for_results();
      send_sample(7'd0);
      send_sample(7'd127);
      wait_for_results();
   endtask

   task automatic test_random_samples();
      int                  sent;
      int                  run_len;
      logic [SAMPLE_W-1:0] s;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 50 == 0) req_idle_on = ($urandom_range(0, 3) != 0);
         if (sent % 250 == 125) wait_for_results();
         if ($urandom_range(0, 99) < 5) begin
            // run of one extreme value so whole windows hold it
            case ($urandom_range(0, 2))
               0: s = 7'd0;
               1: s = 7'd100;
               default: s = SAMPLE_TOP;
            endcase
            run_len = $urandom_range(WINDOW, WINDOW + 5);
            repeat (run_len) send_sample(s);
            sent += run_len;
         end else begin
            if ($urandom_range(0, 99) < 85) s = SAMPLE_W'($urandom_range(0, 100));
            else s = SAMPLE_W'($urandom_range(101, 127));
            send_sample(s);
            sent++;
         end
      end
   endtask

   // result side ready pattern
   initial begin
      int stall;
      int hold;
      rsp_ch.ready = 1'b0;
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_idle_on = ~rsp_idle_on;
         stall = pick_gap(rsp_idle_on);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         hold = $urandom_range(1, 8);
         repeat (hold - 1) @(negedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      window_stats_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_stats.size() == 0) begin
            $error("statistics item with none expected");
            error_count++;
         end else begin
            want = expected_stats.pop_front();
            if (rsp_ch.fill_count !== want.fill_count) begin
               $error("fill_count: expected %0d, got %0d", want.fill_count, rsp_ch.fill_count);
               error_count++;
            end
            if (rsp_ch.mean_q8 !== want.mean_q8) begin
               $error("mean_q8: expected %0d, got %0d", want.mean_q8, rsp_ch.mean_q8);
               error_count++;
            end
            if (rsp_ch.max_value !== want.max_value) begin
               $error("max_value: expected %0d, got %0d", want.max_value, rsp_ch.max_value);
               error_count++;
            end
            if (rsp_ch.min_value !== want.min_value) begin
               $error("min_value: expected %0d, got %0d", want.min_value, rsp_ch.min_value);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** sliding_window_mean_max_min: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ring_fill();
      test_ring_wrap();
      test_drain_pause();
      test_random_samples();

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_stats.size() != 0) begin
         $error("%0d statistics items never arrived", expected_stats.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("** sliding_window_mean_max_min: PASSED **");
      end else begin
         $display("** sliding_window_mean_max_min: FAILED **");
      end
      $finish;
   end

endmodule
